FILE: rtl/best_rational_approximation_unit_macros.svh
// assertion macros for the best rational approximation unit
// no dependencies; included by the top level only
`ifndef BEST_RATIONAL_APPROXIMATION_UNIT_MACROS_SVH
`define BEST_RATIONAL_APPROXIMATION_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define BRA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define BRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bra_pkg.sv
// widths and constants for the best rational approximation unit
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package bra_pkg;
  localparam int WIDTH = 32;
  localparam int MW = WIDTH + 2;
  localparam int PW = 2 * MW;
  localparam int EW = 2 * WIDTH + 2;
  localparam int AW = PW + WIDTH + 1;
  localparam int CW = $clog2(WIDTH);
  localparam logic [WIDTH-2:0] MAXDEN_RESET = (WIDTH - 1)'(1000000);
endpackage

FILE: rtl/bra_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on bra_pkg
`timescale 1ns / 1ps

module bra_div import bra_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  logic [WIDTH:0]   rem;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             run;
  logic [WIDTH:0]   rem_sh;
  logic             ge;
  logic [WIDTH:0]   rem_next;

  assign rem_sh   = {rem[WIDTH-1:0], quo[WIDTH-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign rem_next = ge ? rem_sh - {1'b0, dvs} : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= '0;
        quo <= dividend;
        dvs <= divisor;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        rem <= rem_next;
        quo <= {quo[WIDTH-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(WIDTH - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem[WIDTH-1:0];

endmodule

FILE: rtl/bra_mul.sv
// shared signed multiplier with registered product
// depends on bra_pkg
`timescale 1ns / 1ps

module bra_mul import bra_pkg::*; (
  input  logic                 clk,
  input  logic signed [MW-1:0] op_a,
  input  logic signed [MW-1:0] op_b,
  output logic signed [PW-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

FILE: rtl/best_rational_approximation_unit.sv
// Best rational approximation with a bounded denominator. An item is taken when start is
// high and busy is low; one result follows on done for exactly one cycle and cannot be
// stalled. A denominator within the limit passes straight through, done rising in the next
// cycle. Otherwise each continued-fraction step runs a bit-serial divide with its start and
// registered finish, then the multiplier and the update; the step that overruns the limit
// is followed by the semiconvergent divide with the exact cross-multiplied compare.
// top level: sequencer over bra_div and bra_mul; depends on bra_pkg and the macro header
`timescale 1ns / 1ps
`include "best_rational_approximation_unit_macros.svh"

module best_rational_approximation_unit import bra_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [WIDTH-1:0] numerator_in,
  input  logic [WIDTH-2:0]        denominator_in,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [WIDTH-2:0]        cfg_data,
  output logic                    done,
  output logic signed [WIDTH-1:0] numerator_out,
  output logic [WIDTH-2:0]        denominator_out
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIV_GO, ST_DIV_WAIT, ST_MQ, ST_CQ, ST_UPD,
    ST_KP, ST_KQ, ST_C1, ST_C2, ST_S1, ST_S2,
    ST_L1, ST_L2, ST_R1, ST_R2, ST_CMP, ST_OUT
  } state_t;

  state_t state;

  logic [WIDTH-2:0]        max_den;
  logic [WIDTH-1:0]        lim_in;
  logic signed [WIDTH-1:0] num;
  logic [WIDTH-2:0]        den;
  logic [WIDTH-1:0]        lim;
  logic signed [WIDTH:0]   n;
  logic [WIDTH-1:0]        d;
  logic signed [WIDTH:0]   a;
  logic [WIDTH-1:0]        r;
  logic signed [MW-1:0]    p0, p1, pb;
  logic [WIDTH-1:0]        q0, q1, qn, qb, k;
  logic signed [PW-1:0]    t;
  logic [EW-1:0]           e_conv, e_semi;
  logic [AW-1:0]           acc_l, acc_r;
  logic                    semi;

  logic                    div_start, div_done;
  logic [WIDTH-1:0]        div_dividend, div_divisor, div_quo, div_rem;
  logic signed [MW-1:0]    op_a, op_b;
  logic signed [PW-1:0]    prod;

  logic signed [PW-1:0]    q2;
  logic signed [PW-1:0]    diff;
  logic [PW-1:0]           diff_abs;
  logic signed [MW-1:0]    p2;
  logic [AW-1:0]           prod_ext;
  logic signed [WIDTH:0]   a_next;
  logic [WIDTH-1:0]        r_next;
  logic [WIDTH:0]          n_abs;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign lim_in    = (max_den == '0) ? WIDTH'(1) : {1'b0, max_den};

  // divider operands
  assign n_abs        = n[WIDTH] ? -n : n;
  assign div_start    = (state == ST_DIV_GO);
  assign div_dividend = semi ? lim - q0 : n_abs[WIDTH-1:0];
  assign div_divisor  = semi ? q1 : d;

  bra_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // floor division fix-up for a negative numerator
  always_comb begin
    if (n[WIDTH]) begin
      a_next = -$signed({1'b0, div_quo}) - ((div_rem != '0) ? (WIDTH + 1)'(1) : '0);
      r_next = (div_rem != '0) ? d - div_rem : '0;
    end else begin
      a_next = $signed({1'b0, div_quo});
      r_next = div_rem;
    end
  end

  // multiplier operands by step
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      ST_MQ: begin
        op_a = MW'(a);
        op_b = $signed({2'b0, q1});
      end
      ST_CQ: begin
        op_a = MW'(a);
        op_b = p1;
      end
      ST_KP: begin
        op_a = $signed({2'b0, k});
        op_b = p1;
      end
      ST_KQ: begin
        op_a = $signed({2'b0, k});
        op_b = $signed({2'b0, q1});
      end
      ST_C1: begin
        op_a = p1;
        op_b = $signed({3'b0, den});
      end
      ST_C2: begin
        op_a = MW'(num);
        op_b = $signed({2'b0, q1});
      end
      ST_S1: begin
        op_a = pb;
        op_b = $signed({3'b0, den});
      end
      ST_S2: begin
        op_a = MW'(num);
        op_b = $signed({2'b0, qb});
      end
      ST_L1: begin
        op_a = $signed({1'b0, e_conv[WIDTH:0]});
        op_b = $signed({2'b0, qb});
      end
      ST_L2: begin
        op_a = $signed({1'b0, e_conv[EW-1:WIDTH+1]});
        op_b = $signed({2'b0, qb});
      end
      ST_R1: begin
        op_a = $signed({1'b0, e_semi[WIDTH:0]});
        op_b = $signed({2'b0, q1});
      end
      ST_R2: begin
        op_a = $signed({1'b0, e_semi[EW-1:WIDTH+1]});
        op_b = $signed({2'b0, q1});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  bra_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign q2       = prod + $signed({{(PW - WIDTH){1'b0}}, q0});
  assign p2       = p0 + prod[MW-1:0];
  assign diff     = t - prod;
  assign diff_abs = diff[PW-1] ? -diff : diff;
  assign prod_ext = {{(AW - PW){1'b0}}, prod};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      done    <= 1'b0;
      max_den <= MAXDEN_RESET;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (cfg_valid) begin
            max_den <= cfg_data;
          end
          if (start) begin
            num  <= numerator_in;
            den  <= denominator_in;
            lim  <= lim_in;
            n    <= (WIDTH + 1)'(numerator_in);
            d    <= {1'b0, denominator_in};
            p0   <= '0;
            q0   <= WIDTH'(1);
            p1   <= MW'(1);
            q1   <= '0;
            semi <= 1'b0;
            if ({1'b0, denominator_in} <= lim_in) begin
              numerator_out   <= numerator_in;
              denominator_out <= denominator_in;
              done            <= 1'b1;
            end else begin
              state <= ST_DIV_GO;
            end
          end
        end
        ST_DIV_GO: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            if (semi) begin
              k     <= div_quo;
              state <= ST_KP;
            end else begin
              a     <= a_next;
              r     <= r_next;
              state <= ST_MQ;
            end
          end
        end
        ST_MQ: begin
          state <= ST_CQ;
        end
        ST_CQ: begin
          qn <= q2[WIDTH-1:0];
          if (q2 > $signed({{(PW - WIDTH){1'b0}}, lim})) begin
            semi  <= 1'b1;
            state <= ST_DIV_GO;
          end else begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          p0 <= p1;
          p1 <= p2;
          q0 <= q1;
          q1 <= qn;
          n  <= $signed({1'b0, d});
          d  <= r;
          if (r == '0) begin
            numerator_out   <= p2[WIDTH-1:0];
            denominator_out <= qn[WIDTH-2:0];
            done            <= 1'b1;
            state           <= ST_IDLE;
          end else begin
            state <= ST_DIV_GO;
          end
        end
        ST_KP: begin
          state <= ST_KQ;
        end
        ST_KQ: begin
          pb    <= p2 - p0 + p0;
          state <= ST_C1;
        end
        ST_C1: begin
          qb    <= q2[WIDTH-1:0];
          state <= ST_C2;
        end
        ST_C2: begin
          t     <= prod;
          state <= ST_S1;
        end
        ST_S1: begin
          e_conv <= diff_abs[EW-1:0];
          state  <= ST_S2;
        end
        ST_S2: begin
          t     <= prod;
          state <= ST_L1;
        end
        ST_L1: begin
          e_semi <= diff_abs[EW-1:0];
          state  <= ST_L2;
        end
        ST_L2: begin
          acc_l <= prod_ext;
          state <= ST_R1;
        end
        ST_R1: begin
          acc_l <= acc_l + (prod_ext << (WIDTH + 1));
          state <= ST_R2;
        end
        ST_R2: begin
          acc_r <= prod_ext;
          state <= ST_CMP;
        end
        ST_CMP: begin
          acc_r <= acc_r + (prod_ext << (WIDTH + 1));
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (acc_l <= acc_r) begin
            numerator_out   <= p1[WIDTH-1:0];
            denominator_out <= q1[WIDTH-2:0];
          end else begin
            numerator_out   <= pb[WIDTH-1:0];
            denominator_out <= qb[WIDTH-2:0];
          end
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `BRA_ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "result strobe while busy")
  `BRA_ASSERT_SAME(a_den_limit, clk, rst, done, ({1'b0, denominator_out} <= lim),
    "result denominator above limit")
  `BRA_ASSERT_NEXT(a_long_busy, clk, rst,
    (start && !busy && ({1'b0, denominator_in} > lim_in)), (busy && !done),
    "expansion not started")

endmodule
